[rtl/hse_pkg.sv]
// Package for the HMAC-SHA256 engine: types, constants and round functions.
// Depends on nothing; used by every other file of the block.
package hse_pkg;

   localparam int unsigned KeyWords = 8;
   localparam int unsigned KeyIdxWidth = 3;
   localparam int unsigned CsrIdxWidth = 4;

   localparam logic [31:0] IpadWord = 32'h36363636;
   localparam logic [31:0] OpadWord = 32'h5c5c5c5c;
   localparam logic [31:0] PadWord = 32'h80000000;
   localparam logic [31:0] OuterLenWord = 32'd768;
   localparam logic [63:0] IpadBits = 64'd512;

   typedef logic [31:0] word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_IPAD_LOAD,
      ST_IPAD_RUN,
      ST_ABSORB,
      ST_MSG_RUN,
      ST_PAD_FILL,
      ST_PAD_RUN,
      ST_OPAD_LOAD,
      ST_OPAD_RUN,
      ST_OUTER_LOAD,
      ST_OUTER_RUN,
      ST_EMIT
   } state_type;

   // Sources for the block buffer loads.
   typedef enum logic [2:0] {
      LD_NONE,
      LD_IPAD,
      LD_OPAD,
      LD_OUTER
   } load_type;

   typedef struct packed {
      load_type   load;
      logic       init_hash;   // reset hash_state to the initial value
      logic       start_round; // copy hash into a..h, start 64 rounds
      logic       push;        // write push_word into the buffer
      word_type   push_word;
      logic       save_inner;  // capture hash_state as inner digest
   } dp_cmd_type;

   typedef struct packed {
      logic busy;       // rounds running
      logic block_done; // final round and accumulate this cycle
      logic [4:0] fill;
   } dp_status_type;

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   localparam logic [31:0] InitValue [8] = '{
      32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
      32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

   function automatic word_type ror32(input word_type x, input int unsigned n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

endpackage

[rtl/hse_if.sv]
// Valid/ready channel interfaces for the HMAC-SHA256 engine.
// Depends on hse_pkg for the word type.
interface hse_req_if;
   logic                 valid;
   logic                 ready;
   hse_pkg::word_type    data_word;
   logic [2:0]           valid_bytes;
   logic                 last;
   modport source (output valid, data_word, valid_bytes, last, input ready);
   modport sink (input valid, data_word, valid_bytes, last, output ready);
endinterface

interface hse_rsp_if;
   logic                 valid;
   logic                 ready;
   hse_pkg::word_type    digest_word;
   logic [2:0]           word_index;
   logic                 last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

interface hse_csr_if;
   logic                 valid;
   logic                 ready;
   logic [hse_pkg::CsrIdxWidth-1:0] index;
   logic [63:0]          wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

[rtl/hse_datapath.sv]
// Datapath: block buffer, rolling schedule, one SHA-256 round per cycle.
// Depends on hse_pkg; driven by hse_controller through a command struct.
module hse_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  hse_pkg::dp_cmd_type    cmd,
   input  logic [63:0]            key_flat [8],
   output hse_pkg::dp_status_type status,
   output hse_pkg::word_type      hash_out [8]
);
   import hse_pkg::*;

   word_type buf_ff [16];
   word_type win_ff [16];
   word_type hash_ff [8];
   word_type var_ff [8];
   word_type inner_ff [8];
   logic [4:0] fill_ff;
   logic [5:0] round_ff;
   logic       busy_ff;

   word_type w_t, x2, x15, s1, ch, s0, mj, t1, t2, a, e;

   always_comb begin
      x2  = win_ff[14];
      x15 = win_ff[1];
      if (round_ff < 6'd16) begin
         w_t = win_ff[0];
      end else begin
         w_t = (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10)) + win_ff[9]
             + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) + win_ff[0];
      end
      a  = var_ff[0];
      e  = var_ff[4];
      s1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
      ch = (e & var_ff[5]) ^ (~e & var_ff[6]);
      t1 = var_ff[7] + s1 + ch + RoundK[round_ff] + w_t;
      s0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
      mj = (a & var_ff[1]) ^ (a & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
      t2 = s0 + mj;
   end

   // The window shifts by one each round; slot 0 is word t, or t-16 from round 16.
   always_ff @(posedge clock) begin
      if (cmd.start_round) begin
         win_ff <= buf_ff;
         var_ff <= hash_ff;
      end else if (busy_ff) begin
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
         win_ff[15] <= w_t;
         for (int j = 7; j > 0; j--) begin
            if (j != 4) var_ff[j] <= var_ff[j-1];
         end
         var_ff[4] <= var_ff[3] + t1;
         var_ff[0] <= t1 + t2;
      end
      case (cmd.load)
         LD_IPAD, LD_OPAD: begin
            for (int i = 0; i < 8; i++) begin
               buf_ff[2*i]   <= key_flat[i][63:32] ^
                                ((cmd.load == LD_IPAD) ? IpadWord : OpadWord);
               buf_ff[2*i+1] <= key_flat[i][31:0] ^
                                ((cmd.load == LD_IPAD) ? IpadWord : OpadWord);
            end
         end
         LD_OUTER: begin
            for (int i = 0; i < 8; i++) buf_ff[i] <= inner_ff[i];
            buf_ff[8] <= PadWord;
            for (int i = 9; i < 15; i++) buf_ff[i] <= '0;
            buf_ff[15] <= OuterLenWord;
         end
         default: begin
            if (cmd.push) buf_ff[fill_ff[3:0]] <= cmd.push_word;
         end
      endcase
      if (cmd.save_inner) inner_ff <= hash_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= '0;
         fill_ff  <= '0;
         hash_ff  <= InitValue;
      end else begin
         if (cmd.init_hash) hash_ff <= InitValue;
         if (cmd.start_round) begin
            busy_ff  <= 1'b1;
            round_ff <= '0;
         end else if (busy_ff) begin
            round_ff <= round_ff + 6'd1;
            if (round_ff == 6'd63) busy_ff <= 1'b0;
         end
         if (busy_ff && !cmd.start_round && round_ff == 6'd63) begin
            hash_ff[0] <= hash_ff[0] + t1 + t2;
            for (int j = 1; j < 8; j++) begin
               hash_ff[j] <= hash_ff[j] + ((j == 4) ? var_ff[3] + t1 : var_ff[j-1]);
            end
         end
         if (cmd.start_round) fill_ff <= '0;
         else if (cmd.push) fill_ff <= fill_ff + 5'd1;
      end
   end

   assign status.busy = busy_ff;
   assign status.block_done = busy_ff && (round_ff == 6'd63);
   assign status.fill = fill_ff;
   assign hash_out = hash_ff;
endmodule

[rtl/hse_controller.sv]
// Controller state machine: message framing, padding and the HMAC sequence.
// Depends on hse_pkg; commands hse_datapath and drives the channel handshakes.
module hse_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  hse_pkg::word_type      req_data_word,
   input  logic [2:0]             req_valid_bytes,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_index,
   input  hse_pkg::dp_status_type status,
   output hse_pkg::dp_cmd_type    cmd
);
   import hse_pkg::*;

   state_type  state_ff, state_in;
   logic [63:0] len_ff, len_in;
   logic [2:0]  out_ff, out_in;
   logic        tail_ff, tail_in;   // second pad word (0x80) still owed
   logic        final_ff, final_in; // length words go into the current block
   logic        have_ff, have_in;   // a held word waiting for the buffer
   word_type    held_ff, held_in;
   logic        last_ff, last_in;
   logic [2:0]  vb_ff, vb_in;

   logic [2:0] vb_eff;
   word_type   mask, last_wd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         out_ff   <= '0;
         tail_ff  <= 1'b0;
         final_ff <= 1'b0;
         have_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         out_ff   <= out_in;
         tail_ff  <= tail_in;
         final_ff <= final_in;
         have_ff  <= have_in;
      end
      held_ff      <= held_in;
      last_ff      <= last_in;
      vb_ff        <= vb_in;
   end

   always_comb begin
      vb_eff = (!last_ff || vb_ff > 3'd4) ? 3'd4 : vb_ff;
      case (vb_eff)
         3'd0:    mask = 32'h00000000;
         3'd1:    mask = 32'hff000000;
         3'd2:    mask = 32'hffff0000;
         3'd3:    mask = 32'hffffff00;
         default: mask = 32'hffffffff;
      endcase
      case (vb_eff)
         3'd0:    last_wd = PadWord;
         3'd1:    last_wd = (held_ff & mask) | 32'h00800000;
         3'd2:    last_wd = (held_ff & mask) | 32'h00008000;
         3'd3:    last_wd = (held_ff & mask) | 32'h00000080;
         default: last_wd = held_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      out_in       = out_ff;
      tail_in      = tail_ff;
      final_in     = final_ff;
      have_in      = have_ff;
      held_in      = held_ff;
      last_in      = last_ff;
      vb_in        = vb_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      rsp_index    = out_ff;
      cmd          = '0;
      cmd.load     = LD_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               held_in = req_data_word;
               vb_in   = req_valid_bytes;
               last_in = req_last;
               have_in = 1'b1;
               state_in = ST_IPAD_LOAD;
            end
         end
         ST_IPAD_LOAD: begin
            cmd.load = LD_IPAD;
            cmd.init_hash = 1'b1;
            len_in = IpadBits;
            tail_in = 1'b0;
            final_in = 1'b0;
            state_in = ST_IPAD_RUN;
         end
         ST_IPAD_RUN: begin
            // The buffer is free once the rounds start, so words go in meanwhile.
            cmd.start_round = 1'b1;
            state_in = ST_ABSORB;
         end
         ST_ABSORB: begin
            // Buffer a held word, or fetch a new one.
            if (have_ff) begin
               cmd.push = 1'b1;
               have_in  = 1'b0;
               len_in   = len_ff + {58'd0, vb_eff, 3'd0};
               if (last_ff) begin
                  cmd.push_word = last_wd;
                  tail_in = (vb_eff == 3'd4);
                  state_in = ST_PAD_FILL;
               end else begin
                  cmd.push_word = held_ff;
                  if (status.fill == 5'd15) state_in = ST_MSG_RUN;
               end
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  held_in = req_data_word;
                  vb_in   = req_valid_bytes;
                  last_in = req_last;
                  have_in = 1'b1;
               end
            end
         end
         ST_MSG_RUN: begin
            // The buffer is full; start it as soon as the previous block ends.
            if (!status.busy) begin
               cmd.start_round = 1'b1;
               state_in = ST_ABSORB;
            end
         end
         ST_PAD_FILL: begin
            if (status.fill == 5'd16) begin
               if (!status.busy) begin
                  cmd.start_round = 1'b1;
                  if (final_ff) state_in = ST_PAD_RUN;
               end
            end else if (tail_ff) begin
               cmd.push = 1'b1;
               cmd.push_word = PadWord;
               tail_in = 1'b0;
            end else if (status.fill == 5'd14) begin
               cmd.push = 1'b1;
               cmd.push_word = len_ff[63:32];
               final_in = 1'b1;
            end else if (status.fill == 5'd15 && final_ff) begin
               cmd.push = 1'b1;
               cmd.push_word = len_ff[31:0];
            end else begin
               cmd.push = 1'b1;
               cmd.push_word = '0;
            end
         end
         ST_PAD_RUN: begin
            if (!status.busy) state_in = ST_OPAD_LOAD;
         end
         ST_OPAD_LOAD: begin
            cmd.save_inner = 1'b1;
            cmd.load = LD_OPAD;
            cmd.init_hash = 1'b1;
            state_in = ST_OPAD_RUN;
         end
         ST_OPAD_RUN: begin
            cmd.start_round = 1'b1;
            state_in = ST_OUTER_LOAD;
         end
         ST_OUTER_LOAD: begin
            cmd.load = LD_OUTER;
            if (!status.busy) state_in = ST_OUTER_RUN;
         end
         ST_OUTER_RUN: begin
            cmd.start_round = 1'b1;
            state_in = ST_EMIT;
            out_in = '0;
         end
         ST_EMIT: begin
            if (!status.busy) begin
               rsp_valid = 1'b1;
               if (rsp_ready) begin
                  out_in = out_ff + 3'd1;
                  if (out_ff == 3'd7) begin
                     state_in = ST_IDLE;
                     len_in = '0;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[rtl/hmac_sha256_engine_unit.sv]
// Top level of the HMAC-SHA256 engine: key registers, controller, datapath.
// Depends on hse_pkg, hse_if, hse_controller and hse_datapath.
//
//   channel  dir  beat payload                          accepted when
//   req      in   data_word, valid_bytes, last          req.valid && req.ready
//   rsp      out  digest_word, word_index, last_word    rsp.valid && rsp.ready
//   csr      in   index, wdata (key_word_0..7)          csr.valid && csr.ready
//
// Each 16-word block runs on the single round unit in the datapath, and the
// buffer refills while the rounds run, so words for the next block are taken
// meanwhile. The first beat of a message also starts the ipad block. The last
// beat adds one padding block (two when fewer than two buffer words remain for
// the length), the opad block and the outer block. req.ready stays low while a
// full buffer waits for a running block and from the last beat until the eighth
// digest beat is taken. Reset is synchronous and clears the control state and
// the key registers and sets the hash state to its initial value; there is no
// clearing pass. A stalled rsp beat holds.
module hmac_sha256_engine_unit (
   input logic clock,
   input logic reset,
   hse_req_if.sink   req,
   hse_rsp_if.source rsp,
   hse_csr_if.sink   csr
);
   import hse_pkg::*;

   logic [63:0]   key_ff [8];
   dp_cmd_type    cmd;
   dp_status_type status;
   word_type      hash_w [8];
   logic [2:0]    idx;

   // The key registers take a write in any cycle; indexes past the list drop.
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KeyWords; i++) key_ff[i] <= '0;
      end else if (csr.valid && csr.index < CsrIdxWidth'(KeyWords)) begin
         key_ff[csr.index[KeyIdxWidth-1:0]] <= csr.wdata;
      end
   end

   hse_controller u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .req_data_word(req.data_word), .req_valid_bytes(req.valid_bytes),
      .req_last(req.last),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_index(idx),
      .status, .cmd
   );

   hse_datapath u_dp (
      .clock, .reset, .cmd, .key_flat(key_ff), .status, .hash_out(hash_w)
   );

   assign rsp.digest_word = hash_w[idx];
   assign rsp.word_index  = idx;
   assign rsp.last_word   = (idx == 3'd7);
endmodule

[dv/hse_tb_if.sv]
// Testbench types: the digest beat struct that the checker queues.
// The interfaces themselves live in rtl/hse_if.sv and depend on hse_pkg.
package hse_tb_types;
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;
endpackage

[dv/hse_checker.sv]
// Checker for the HMAC-SHA256 engine: watches the csr, req and rsp channels,
// predicts the digest beats with its own SHA-256 and compares them in order.
// Depends on hse_pkg, hse_if and hse_tb_types.
module hse_checker (
   input logic clock,
   input logic reset,
   hse_req_if.sink req,
   hse_rsp_if.sink rsp,
   hse_csr_if.sink csr,
   output int fail_count,
   output int pending_count
);
   import hse_pkg::*;
   import hse_tb_types::*;

   logic [63:0] key_reg [8];
   word_type    chain [8];
   word_type    blk [16];
   logic [63:0] msg_bits;
   int          fill;
   logic        busy_msg;
   digest_beat_type digest_queue [$];

   function automatic word_type rotr(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress();
      word_type w [16];
      word_type v [8];
      word_type x, t1, t2, e, a;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < 64; t++) begin
         if (t >= 16) begin
            x = (rotr(w[(t-2)&15],17) ^ rotr(w[(t-2)&15],19) ^ (w[(t-2)&15] >> 10))
              + w[(t-7)&15]
              + (rotr(w[(t-15)&15],7) ^ rotr(w[(t-15)&15],18) ^ (w[(t-15)&15] >> 3))
              + w[t&15];
            w[t&15] = x;
         end
         a = v[0];
         e = v[4];
         t1 = v[7] + (rotr(e,6) ^ rotr(e,11) ^ rotr(e,25)) + ((e & v[5]) ^ (~e & v[6]))
            + RoundK[t] + w[t&15];
         t2 = (rotr(a,2) ^ rotr(a,13) ^ rotr(a,22)) ^ 32'h0;
         t2 = t2 + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
         for (int j = 7; j > 0; j--) v[j] = v[j-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
   endtask

   task automatic keyed_start(word_type pad);
      for (int i = 0; i < 8; i++) chain[i] = InitValue[i];
      for (int i = 0; i < 8; i++) begin
         blk[2*i]   = key_reg[i][63:32] ^ pad;
         blk[2*i+1] = key_reg[i][31:0] ^ pad;
      end
      compress();
   endtask

   task automatic absorb(word_type w);
      blk[fill] = w;
      fill++;
      if (fill == 16) begin
         compress();
         fill = 0;
      end
   endtask

   task automatic predict_beat(word_type data, logic [2:0] nbytes, logic fin);
      word_type inner [8];
      word_type mask;
      int n;
      if (!busy_msg) begin
         keyed_start(IpadWord);
         msg_bits = IpadBits;
         fill = 0;
         busy_msg = 1'b1;
      end
      n = (!fin || nbytes > 4) ? 4 : int'(nbytes);
      msg_bits += 64'(8 * n);
      if (!fin) begin
         absorb(data);
         return;
      end
      if (n == 4) begin
         absorb(data);
         absorb(PadWord);
      end else begin
         mask = (n == 0) ? '0 : ~(32'hffffffff >> (8 * n));
         absorb((data & mask) | (32'h80 << (24 - 8 * n)));
      end
      if (fill > 14) while (fill != 0) absorb('0);
      while (fill < 14) absorb('0);
      absorb(msg_bits[63:32]);
      absorb(msg_bits[31:0]);
      for (int i = 0; i < 8; i++) inner[i] = chain[i];
      keyed_start(OpadWord);
      for (int i = 0; i < 8; i++) blk[i] = inner[i];
      blk[8] = PadWord;
      for (int i = 9; i < 15; i++) blk[i] = '0;
      blk[15] = OuterLenWord;
      compress();
      for (int i = 0; i < 8; i++) digest_queue.push_back({chain[i], 3'(i), i == 7});
      busy_msg = 1'b0;
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s: got %h, expected %h", what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      busy_msg = 1'b0;
      fill = 0;
      msg_bits = '0;
      for (int i = 0; i < 8; i++) key_reg[i] = '0;
   end

   always @(posedge clock) begin
      digest_beat_type want;
      if (reset) begin
         busy_msg = 1'b0;
      end else begin
         if (csr.valid && csr.ready && csr.index < KeyWords)
            key_reg[csr.index[KeyIdxWidth-1:0]] = csr.wdata;
         if (req.valid && req.ready) predict_beat(req.data_word, req.valid_bytes, req.last);
         if (rsp.valid && rsp.ready) begin
            if (digest_queue.size() == 0) begin
               report("unexpected beat", rsp.digest_word, '0);
            end else begin
               want = digest_queue.pop_front();
               if (rsp.digest_word !== want.digest_word)
                  report("digest_word", rsp.digest_word, want.digest_word);
               if (rsp.word_index !== want.word_index)
                  report("word_index", 32'(rsp.word_index), 32'(want.word_index));
               if (rsp.last_word !== want.last_word)
                  report("last_word", 32'(rsp.last_word), 32'(want.last_word));
            end
         end
         pending_count = digest_queue.size();
      end
   end
endmodule

[dv/testbench.sv]
// Top of the HMAC-SHA256 engine testbench: clock, reset, stimulus, verdict.
// Depends on hse_pkg, hse_if, hse_tb_types, hse_checker and the engine RTL.
module testbench;
   import hse_pkg::*;

   localparam int StallLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   idle_cycles = 0;

   hse_req_if req ();
   hse_rsp_if rsp ();
   hse_csr_if csr ();

   hmac_sha256_engine_unit uut (.clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr));
   hse_checker chk (.clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr),
      .fail_count(fail_count), .pending_count(pending_count));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The watchdog counts cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready)
          || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
         $display("** hmac_sha256_engine_unit: FAILED **");
         $finish;
      end
   end

   // The result side drops ready after every beat and adds a random gap, sometimes none.
   initial begin
      int gap;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         repeat (gap) @(negedge clock);
         rsp.ready = 1'b1;
         do @(posedge clock); while (!rsp.valid);
         @(negedge clock);
         rsp.ready = 1'b0;
      end
   end

   // Sends one beat on the request channel after a random gap (none when calm); valid
   // stays high only until the handshake is seen at a rising edge.
   task automatic send_beat(logic [31:0] data, logic [2:0] nbytes, logic fin, bit calm);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      repeat (gap) @(negedge clock);
      req.valid = 1'b1;
      req.data_word = data;
      req.valid_bytes = nbytes;
      req.last = fin;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      req.valid = 1'b0;
      req.data_word = $urandom;
   endtask

   // Writes a key register; called only when the engine has nothing in flight.
   task automatic write_key(int idx, logic [63:0] value);
      csr.valid = 1'b1;
      csr.index = idx[CsrIdxWidth-1:0];
      csr.wdata = value;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   // Waits for every predicted digest beat, then lets the engine settle.
   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // A message of the given word count with a final beat of the given size.
   task automatic send_message(int words, logic [2:0] tail_bytes, bit calm);
      for (int i = 0; i < words; i++)
         send_beat($urandom, 3'($urandom_range(0, 7)), 1'b0, calm);
      send_beat($urandom, tail_bytes, 1'b1, calm);
   endtask

   task automatic load_key(int kind);
      logic [63:0] v;
      for (int i = 0; i < KeyWords; i++) begin
         case (kind)
            0: v = '0;
            1: v = '1;
            default: v = {$urandom, $urandom};
         endcase
         // Short keys: zero-filled tail words now and then.
         if (kind > 2 && i >= kind) v = '0;
         write_key(i, v);
      end
   endtask

   initial begin
      int sent;
      int words;
      req.valid = 1'b0;
      req.data_word = '0;
      req.valid_bytes = '0;
      req.last = 1'b0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.wdata = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed part: reset key, all-zero and all-one words, every tail size,
      // oversized counts, short words without last, and the padding boundary.
      send_beat('0, 3'd0, 1'b1, 1'b1);
      send_beat('1, 3'd4, 1'b1, 1'b0);
      drain();
      load_key(1);
      for (int b = 0; b < 8; b++) send_beat('1, 3'(b), 1'b1, 1'b0);
      send_beat(32'hdeadbeef, 3'd1, 1'b0, 1'b0);
      send_beat(32'h01234567, 3'd7, 1'b1, 1'b0);
      drain();
      load_key(2);
      send_message(13, 3'd4, 1'b0);
      send_message(14, 3'd2, 1'b1);
      drain();
      sent = 41;

      // Random part: mostly short messages, some spanning blocks, random byte counts.
      // The key changes between phases, extremes included.
      while (sent < 280) begin
         if ($urandom_range(0, 5) == 0) begin
            drain();
            load_key($urandom_range(0, 7));
         end
         words = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 6);
         send_message(words, 3'($urandom_range(0, 7)), $urandom_range(0, 4) == 0);
         sent += words + 1;
      end
      drain();
      if (fail_count == 0) begin
         $display("** hmac_sha256_engine_unit: PASSED **");
      end else begin
         $display("** hmac_sha256_engine_unit: FAILED **");
      end
      $finish;
   end
endmodule
